>>> hw/rtl/psq_pkg.sv
// Shared types, codes and defaults for the positional sequence table.
package psq_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int ITEM_WIDTH_DEF = 32;

	// Operation codes carried in the request.
	localparam logic [2:0] FN_INSERT_AT = 3'd0;
	localparam logic [2:0] FN_SORTED    = 3'd1;
	localparam logic [2:0] FN_ERASE     = 3'd2;
	localparam logic [2:0] FN_REMOVE    = 3'd3;
	localparam logic [2:0] FN_GET       = 3'd4;
	localparam logic [2:0] FN_SET       = 3'd5;
	localparam logic [2:0] FN_FIND      = 3'd6;

	// Status codes returned with every result.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [2:0]  func;
		logic [6:0]  position;
		logic [31:0] item_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  result_index;
		logic [31:0] read_value;
		logic [6:0]  removed_count;
		logic [6:0]  item_count;
		logic        is_empty;
	} rsp_t;

endpackage

>>> hw/rtl/psq_chan_if.sv
// Valid/ready channel that carries one request or result payload.
interface psq_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/positional_sequence_table_top.sv
// Bounded ordered list with positional and sorted insert, erase, remove, get, set and find.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid / ready | psq_pkg::req_t (func, position, item_value)
//   rsp     | out | valid / ready | psq_pkg::rsp_t (status ... is_empty)
//
// One request is worked at a time; ready is high only while the sequencer is idle.
// Insert at and erase shift the items from the position to the end of the list, remove
// all compacts the whole list, find scans it until a match, and sorted insert scans to
// the first item not below the value and then shifts the rest up. The single read port
// of the item RAM moves one item per cycle.
// Reset clears the count and the control state; the RAM is not cleared.
// A finished result waits in the output register; the sequencer holds in its last
// state while that register is still full.
module positional_sequence_table_top #(
	parameter int DEPTH      = psq_pkg::DEPTH_DEF,
	parameter int ITEM_WIDTH = psq_pkg::ITEM_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	psq_chan_if.sink   req,
	psq_chan_if.source rsp
);
	import psq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > 7) ? CW : 7;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_START   = 4'd1;
	localparam logic [3:0] S_SCAN    = 4'd2;
	localparam logic [3:0] S_SHUP    = 4'd3;
	localparam logic [3:0] S_PLACE   = 4'd4;
	localparam logic [3:0] S_SHDN    = 4'd5;
	localparam logic [3:0] S_COMPACT = 4'd6;
	localparam logic [3:0] S_GETW    = 4'd7;
	localparam logic [3:0] S_FIN     = 4'd8;

	logic [3:0]            state_q;
	logic [CW-1:0]         count_q;
	logic [2:0]            func_q;
	logic [6:0]            pos_q;
	logic [ITEM_WIDTH-1:0] val_q;
	logic [CW-1:0]         ptr_q;
	logic [CW-1:0]         tgt_q;
	logic [CW-1:0]         k_q;
	logic [CW-1:0]         rem_q;
	logic [CW-1:0]         idx_q;
	logic [1:0]            status_q;
	logic [31:0]           readv_q;
	logic                  pend_s1;
	logic [AW-1:0]         paddr_s1;
	logic                  out_valid_q;
	rsp_t                  out_q;

	logic                  we;
	logic [AW-1:0]         waddr;
	logic [ITEM_WIDTH-1:0] wdata;
	logic [AW-1:0]         raddr;
	logic [ITEM_WIDTH-1:0] rdata;
	logic                  issue;
	logic                  hit;
	logic [CW-1:0]         ptr_dec;
	logic [XW-1:0]         posx;
	logic [XW-1:0]         cntx;
	logic                  full;
	logic                  out_free;

	psq_ram #(
		.WIDTH(ITEM_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign ptr_dec  = ptr_q - CW'(1);
	assign posx     = XW'(pos_q);
	assign cntx     = XW'(count_q);
	assign full     = (count_q == CW'(DEPTH));
	assign out_free = !out_valid_q || rsp.ready;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// Read issue per state; an issued read comes back in the next cycle as pend_s1, except in the scan once a hit is seen.
	always_comb begin
		issue = 1'b0;
		raddr = ptr_q[AW-1:0];
		unique case (state_q) inside
			S_SCAN, S_SHDN, S_COMPACT: begin
				issue = (ptr_q < count_q);
			end
			S_SHUP: begin
				issue = (ptr_q > tgt_q);
				raddr = ptr_dec[AW-1:0];
			end
			S_START: begin
				raddr = AW'(pos_q);
			end
			default: begin
			end
		endcase
	end

	// Hit test for the scan: sorted insert stops at the first item not below the value, find at the first equal item.
	always_comb begin
		if (func_q == FN_SORTED) begin
			hit = pend_s1 && (val_q <= rdata);
		end else begin
			hit = pend_s1 && (val_q == rdata);
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = paddr_s1;
		wdata = rdata;
		unique case (state_q) inside
			S_SHUP, S_SHDN: begin
				we = pend_s1;
			end
			S_PLACE: begin
				if (pend_s1) begin
					we = 1'b1;
				end else begin
					we    = 1'b1;
					waddr = tgt_q[AW-1:0];
					wdata = val_q;
				end
			end
			S_COMPACT: begin
				we    = pend_s1 && (rdata != val_q);
				waddr = k_q[AW-1:0];
			end
			S_START: begin
				we    = (func_q == FN_SET) && (posx < cntx);
				waddr = AW'(pos_q);
				wdata = val_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			pend_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					unique case (func_q)
						FN_INSERT_AT: begin
							if (full || posx > cntx) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_SHUP;
							end
						end
						FN_SORTED: begin
							state_q <= full ? S_FIN : S_SCAN;
						end
						FN_ERASE: begin
							state_q <= (posx >= cntx) ? S_FIN : S_SHDN;
						end
						FN_REMOVE: begin
							state_q <= S_COMPACT;
						end
						FN_GET: begin
							state_q <= (posx >= cntx) ? S_FIN : S_GETW;
						end
						FN_FIND: begin
							state_q <= S_SCAN;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_SCAN: begin
					pend_s1 <= issue && !hit;
					if (hit) begin
						state_q <= (func_q == FN_SORTED) ? S_SHUP : S_FIN;
					end else if (!issue && !pend_s1) begin
						state_q <= (func_q == FN_SORTED) ? S_SHUP : S_FIN;
					end
				end
				S_SHUP: begin
					pend_s1 <= issue;
					if (!issue) begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					if (!pend_s1) begin
						count_q <= count_q + CW'(1);
						state_q <= S_FIN;
					end
				end
				S_SHDN: begin
					pend_s1 <= issue;
					if (!issue && !pend_s1) begin
						count_q <= count_q - CW'(1);
						state_q <= S_FIN;
					end
				end
				S_COMPACT: begin
					pend_s1 <= issue;
					if (!issue && !pend_s1) begin
						count_q <= k_q;
						state_q <= S_FIN;
					end
				end
				S_GETW: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: request fields, pointers and result fields.
	always_ff @(posedge clk) begin
		if (issue) begin
			paddr_s1 <= (state_q == S_SHUP) ? ptr_q[AW-1:0] :
			            (state_q == S_SHDN) ? ptr_dec[AW-1:0] : ptr_q[AW-1:0];
		end
		unique case (state_q) inside
			S_IDLE: begin
				func_q   <= req.data.func;
				pos_q    <= req.data.position;
				val_q    <= ITEM_WIDTH'(req.data.item_value);
				status_q <= ST_OK;
				idx_q    <= '0;
				readv_q  <= '0;
				rem_q    <= '0;
				k_q      <= '0;
				ptr_q    <= '0;
			end
			S_START: begin
				unique case (func_q) inside
					FN_INSERT_AT: begin
						if (full) begin
							status_q <= ST_FULL;
						end else if (posx > cntx) begin
							status_q <= ST_RANGE;
						end
						tgt_q <= CW'(pos_q);
						ptr_q <= count_q;
					end
					FN_SORTED: begin
						if (full) begin
							status_q <= ST_FULL;
						end
					end
					FN_ERASE: begin
						if (posx >= cntx) begin
							status_q <= ST_RANGE;
						end
						ptr_q <= CW'(pos_q) + CW'(1);
					end
					FN_GET, FN_SET: begin
						if (posx >= cntx) begin
							status_q <= ST_RANGE;
						end
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				if (issue) begin
					ptr_q <= ptr_q + CW'(1);
				end
				if (hit) begin
					idx_q <= CW'(paddr_s1);
					tgt_q <= CW'(paddr_s1);
					ptr_q <= count_q;
				end else if (!issue && !pend_s1) begin
					tgt_q <= count_q;
					ptr_q <= count_q;
					if (func_q == FN_FIND) begin
						status_q <= ST_NOTFOUND;
					end
				end
			end
			S_SHUP, S_SHDN: begin
				if (issue) begin
					ptr_q <= (state_q == S_SHUP) ? ptr_dec : ptr_q + CW'(1);
				end
			end
			S_PLACE: begin
				idx_q <= tgt_q;
			end
			S_COMPACT: begin
				if (issue) begin
					ptr_q <= ptr_q + CW'(1);
				end
				if (pend_s1) begin
					if (rdata == val_q) begin
						rem_q <= rem_q + CW'(1);
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
			end
			S_GETW: begin
				readv_q <= 32'(rdata);
			end
			S_FIN: begin
				if (out_free) begin
					out_q.status        <= status_q;
					out_q.result_index  <= 6'(idx_q);
					out_q.read_value    <= readv_q;
					out_q.removed_count <= 7'(rem_q);
					out_q.item_count    <= 7'(count_q);
					out_q.is_empty      <= (count_q == '0);
				end
			end
			default: begin
			end
		endcase
	end
endmodule

>>> hw/rtl/psq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module psq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
